// File: hw/rtl/cpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants of the clock page replacement core.
// ----------------------------------------------------------------------------
package cpr_pkg;

   localparam int FRAMES     = 64;
   localparam int FRAME_BITS = 6;
   localparam int PID_BITS   = 8;
   localparam int PAGE_BITS  = 12;
   localparam int QDEPTH     = 2;

   localparam logic [1:0] FUNC_ACCESS = 2'd0;
   localparam logic [1:0] FUNC_LOAD   = 2'd1;
   localparam logic [1:0] FUNC_VICTIM = 2'd2;

   localparam logic [2:0] ST_DONE    = 3'd0;
   localparam logic [2:0] ST_VICTIM  = 3'd1;
   localparam logic [2:0] ST_ALLOC   = 3'd2;
   localparam logic [2:0] ST_NOFREE  = 3'd3;
   localparam logic [2:0] ST_NOVICT  = 3'd4;

   localparam logic CSR_FPP = 1'b0;
   localparam logic CSR_ENH = 1'b1;

   typedef enum logic [1:0] {OP_ACCESS, OP_LOAD, OP_VICTIM, OP_NOP} op_type;

   typedef struct packed {
      op_type                op;
      logic [PID_BITS-1:0]   pid;
      logic [FRAME_BITS-1:0] frame;
      logic                  wr;
      logic [PAGE_BITS-1:0]  page;
   } cmd_type;

   typedef struct packed {
      logic [6:0]           frame;
      logic [PAGE_BITS-1:0] page;
      logic                 wb;
      logic [2:0]           status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_COUNT, S_ALLOC, S_SCAN, S_OUT
   } state_type;

endpackage
`default_nettype wire

// File: hw/rtl/cpr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_front
// Accepts request words, classifies them and queues commands for the engine.
// ----------------------------------------------------------------------------
module cpr_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [1:0]                   req_func,
   input  wire  [cpr_pkg::PID_BITS-1:0] req_process_id,
   input  wire  [5:0]                   req_frame_index,
   input  wire                          req_is_write,
   input  wire  [11:0]                  req_page_number,
   output logic                         cmd_valid,
   input  wire                          cmd_take,
   output cpr_pkg::cmd_type             cmd
);
   cpr_pkg::cmd_type q_ff [cpr_pkg::QDEPTH];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   cpr_pkg::cmd_type c;
   logic             push;

   always_comb begin
      case (req_func)
         cpr_pkg::FUNC_ACCESS: c.op = cpr_pkg::OP_ACCESS;
         cpr_pkg::FUNC_LOAD:   c.op = cpr_pkg::OP_LOAD;
         cpr_pkg::FUNC_VICTIM: c.op = cpr_pkg::OP_VICTIM;
         default:              c.op = cpr_pkg::OP_NOP;
      endcase
      c.pid   = req_process_id;
      c.frame = req_frame_index;
      c.wr    = req_is_write;
      c.page  = req_page_number;
   end

   assign req_stall = (cnt_ff == 2'(cpr_pkg::QDEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff + 1'(push);
      rp_in  = rp_ff + 1'(cmd_take);
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= c;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/cpr_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_engine
// Frame table and the sequencer that counts, allocates and runs clock scans.
// ----------------------------------------------------------------------------
module cpr_engine (
   input  wire               clock,
   input  wire               reset,
   input  wire               cmd_valid,
   output logic              cmd_take,
   input  cpr_pkg::cmd_type  cmd,
   input  wire  [6:0]        fpp,
   input  wire               enh,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output cpr_pkg::rsp_type  rsp
);
   localparam int FB = cpr_pkg::FRAME_BITS;

   logic [cpr_pkg::FRAMES-1:0] own_ff, pres_ff, use_ff, dirty_ff, hand_ff;
   logic [cpr_pkg::PID_BITS-1:0]  pid_ff [cpr_pkg::FRAMES];
   logic [cpr_pkg::PAGE_BITS-1:0] page_ff [cpr_pkg::FRAMES];
   logic [cpr_pkg::PID_BITS-1:0]  pid_rd_ff;  // owner of the frame under the pointer
   logic [cpr_pkg::PAGE_BITS-1:0] pg_rd_ff;   // page held by the victim frame

   cpr_pkg::state_type st_ff, st_in;
   cpr_pkg::cmd_type   c_ff;
   cpr_pkg::rsp_type   r_ff, r_in;
   logic [FB-1:0] f_ff, f_in;       // frame pointer
   logic [6:0]    n_ff, n_in;       // count of present frames
   logic          hf_ff, hf_in;     // hand found
   logic [FB-1:0] hs_ff, hs_in;     // scan start
   logic [FB-1:0] first_ff, first_in;
   logic [1:0]    pass_ff, pass_in;
   logic [FB:0]   steps_ff, steps_in;
   logic          vsel_ff, vsel_in; // victim found, now seeking next member
   logic [FB-1:0] vic_ff, vic_in;

   logic mem;
   logic hit, clr_use, last_pass;
   logic [1:0] want;
   logic [FB-1:0] f_nxt;

   assign mem   = own_ff[f_ff] && pid_rd_ff == c_ff.pid && pres_ff[f_ff];
   assign f_nxt = f_ff + 1'b1;

   always_comb begin
      if (enh) begin
         case (pass_ff)
            2'd0:    begin want = 2'd0; clr_use = 1'b0; end
            2'd1:    begin want = 2'd1; clr_use = 1'b1; end
            2'd2:    begin want = 2'd0; clr_use = 1'b1; end
            default: begin want = 2'd1; clr_use = 1'b1; end
         endcase
         last_pass = (pass_ff == 2'd3);
      end else begin
         want = 2'd2; clr_use = (pass_ff == 2'd0);
         last_pass = (pass_ff == 2'd1);
      end
      hit = !use_ff[f_ff] && (want == 2'd2 || {1'b0, dirty_ff[f_ff]} == want);
   end

   assign cmd_take  = (st_ff == cpr_pkg::S_IDLE) && cmd_valid;
   assign rsp_valid = (st_ff == cpr_pkg::S_OUT);
   assign rsp       = r_ff;

   always_comb begin
      st_in = st_ff; f_in = f_ff; n_in = n_ff; hf_in = hf_ff; hs_in = hs_ff;
      first_in = first_ff; pass_in = pass_ff; steps_in = steps_ff;
      vsel_in = vsel_ff; vic_in = vic_ff; r_in = r_ff;
      case (st_ff)
         cpr_pkg::S_IDLE: if (cmd_valid) begin
            r_in = '0;
            f_in = '0; n_in = '0; hf_in = 1'b0; vsel_in = 1'b0;
            st_in = (cmd.op == cpr_pkg::OP_VICTIM) ? cpr_pkg::S_COUNT : cpr_pkg::S_OUT;
         end
         cpr_pkg::S_COUNT: begin
            if (mem) begin
               if (n_ff == 7'd0) first_in = f_ff;
               if (!hf_ff && hand_ff[f_ff]) begin hf_in = 1'b1; hs_in = f_ff; end
               n_in = n_ff + 7'd1;
            end
            f_in = f_nxt;
            if (f_ff == FB'(cpr_pkg::FRAMES-1)) begin
               if (n_in < fpp) begin
                  f_in = '0; st_in = cpr_pkg::S_ALLOC;
               end else begin
                  f_in = hf_in ? hs_in : (n_ff == 7'd0 ? f_ff : first_in);
                  pass_in = 2'd0; steps_in = '0;
                  st_in = (n_in == 7'd0) ? cpr_pkg::S_OUT : cpr_pkg::S_SCAN;
                  if (n_in == 7'd0) r_in = {7'(cpr_pkg::FRAMES), 12'd0, 1'b0, cpr_pkg::ST_NOVICT};
               end
            end
         end
         cpr_pkg::S_ALLOC: begin
            f_in = f_nxt;
            if (!own_ff[f_ff]) begin
               r_in = {1'b0, f_ff, 12'd0, 1'b0, cpr_pkg::ST_ALLOC};
               st_in = cpr_pkg::S_OUT;
            end else if (f_ff == FB'(cpr_pkg::FRAMES-1)) begin
               r_in = {7'(cpr_pkg::FRAMES), 12'd0, 1'b0, cpr_pkg::ST_NOFREE};
               st_in = cpr_pkg::S_OUT;
            end
         end
         cpr_pkg::S_SCAN: begin
            f_in = f_nxt;
            if (vsel_ff) begin
               // The victim's page was read at the edge that found it.
               r_in.page = pg_rd_ff;
               if (mem || f_ff == vic_ff) st_in = cpr_pkg::S_OUT;
            end else if (mem) begin
               if (hit) begin
                  r_in = {1'b0, f_ff, 12'd0, dirty_ff[f_ff], cpr_pkg::ST_VICTIM};
                  vic_in = f_ff; vsel_in = 1'b1;
               end else if (steps_ff + 1'b1 == (FB+1)'(n_ff)) begin
                  steps_in = '0;
                  if (last_pass) begin
                     r_in = {7'(cpr_pkg::FRAMES), 12'd0, 1'b0, cpr_pkg::ST_NOVICT};
                     st_in = cpr_pkg::S_OUT;
                  end else pass_in = pass_ff + 2'd1;
               end else steps_in = steps_ff + 1'b1;
            end
         end
         cpr_pkg::S_OUT: if (!rsp_stall) st_in = cpr_pkg::S_IDLE;
         default: st_in = cpr_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      c_ff <= (st_ff == cpr_pkg::S_IDLE) ? cmd : c_ff;
      f_ff <= f_in; n_ff <= n_in; hs_ff <= hs_in; first_ff <= first_in;
      pass_ff <= pass_in; steps_ff <= steps_in; vic_ff <= vic_in; r_ff <= r_in;
      hf_ff <= hf_in; vsel_ff <= vsel_in;
      // Reads are addressed with the next pointer so the data lines up with f_ff.
      pid_rd_ff <= pid_ff[f_in];
      pg_rd_ff  <= page_ff[vic_in];
      if (st_ff == cpr_pkg::S_IDLE && cmd_valid && cmd.op == cpr_pkg::OP_LOAD)
         page_ff[cmd.frame] <= cmd.page;
      if (st_ff == cpr_pkg::S_ALLOC && !own_ff[f_ff]) pid_ff[f_ff] <= c_ff.pid;
      if (reset) begin
         st_ff <= cpr_pkg::S_IDLE;
         own_ff <= '0; pres_ff <= '0; use_ff <= '0; dirty_ff <= '0; hand_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == cpr_pkg::S_IDLE && cmd_valid) begin
            if (cmd.op == cpr_pkg::OP_ACCESS) begin
               use_ff[cmd.frame] <= 1'b1;
               if (cmd.wr) dirty_ff[cmd.frame] <= 1'b1;
            end
            if (cmd.op == cpr_pkg::OP_LOAD) pres_ff[cmd.frame] <= 1'b1;
         end
         if (st_ff == cpr_pkg::S_ALLOC && !own_ff[f_ff]) own_ff[f_ff] <= 1'b1;
         if (st_ff == cpr_pkg::S_SCAN) begin
            if (vsel_ff) begin
               // Hand lands on the next member after the victim (itself if alone).
               if (mem || f_ff == vic_ff) hand_ff[f_ff] <= 1'b1;
            end else if (mem) begin
               hand_ff[f_ff] <= 1'b0;
               if (hit) begin
                  pres_ff[f_ff] <= 1'b0; use_ff[f_ff] <= 1'b0; dirty_ff[f_ff] <= 1'b0;
               end else if (clr_use) use_ff[f_ff] <= 1'b0;
            end
         end
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/clock_page_replacement_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clock_page_replacement_core
// Frame table with plain and enhanced clock victim selection.
// ----------------------------------------------------------------------------
// Access, load and unused words are answered without a walk. A victim request
// walks the frame table one frame per cycle: it first counts the process's
// present frames, then allocates a free frame if the count is below the limit,
// or makes up to four passes in enhanced mode (two in plain mode) plus one
// partial walk to find the frame after the victim.
// A two-word queue lets new words be taken while the engine works.
module clock_page_replacement_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_func,
   input  wire  [7:0]  req_process_id,
   input  wire  [5:0]  req_frame_index,
   input  wire         req_is_write,
   input  wire  [11:0] req_page_number,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [6:0]  rsp_chosen_frame,
   output logic [11:0] rsp_evicted_page,
   output logic        rsp_writeback,
   output logic [2:0]  rsp_status,
   input  wire         csr_write,
   input  wire  [0:0]  csr_index,
   input  wire  [6:0]  csr_data
);
   logic [6:0] fpp_ff;
   logic       enh_ff;
   logic       cmd_valid, cmd_take;
   cpr_pkg::cmd_type cmd;
   cpr_pkg::rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         fpp_ff <= 7'd4; enh_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_index[0] == cpr_pkg::CSR_FPP) fpp_ff <= csr_data;
         else enh_ff <= csr_data[0];
      end
   end

   cpr_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_process_id,
      .req_frame_index, .req_is_write, .req_page_number,
      .cmd_valid, .cmd_take, .cmd
   );

   cpr_engine u_engine (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd, .fpp(fpp_ff), .enh(enh_ff),
      .rsp_valid, .rsp_stall, .rsp
   );

   assign rsp_chosen_frame = rsp.frame;
   assign rsp_evicted_page = rsp.page;
   assign rsp_writeback    = rsp.wb;
   assign rsp_status       = rsp.status;
endmodule
`default_nettype wire
